// ----- design/gclm_pkg.sv -----
// Shared types, widths and helpers for the grid cavity marker.
// No dependencies; every other design file refers to this package by scoped name.
package gclm_pkg;

  // Default depth of each line store (columns per row)
  localparam int MAX_SIZE_DEF = 128;

  // Field widths
  localparam int CFG_W = 8;  // grid_size register
  localparam int CW    = 8;  // row and column counters
  localparam int VAL_W = 4;  // cell digit
  localparam int ROW_W = 7;  // emitted row index
  localparam int COL_W = 7;  // emitted column index

  // Role rotation of the three line store banks
  typedef enum logic [1:0] {
    BANK_0,
    BANK_1,
    BANK_2
  } bank_sel_t;

  // One result as it leaves the block
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             cav;
    logic             last;
  } result_t;

  // Results still owed by the item in the compare stage
  typedef struct packed {
    logic a;  // cell of the row above
    logic b;  // arriving cell of the last row
  } pend_t;

  // Bank that held the row written before the given one
  function automatic bank_sel_t prev_bank(input bank_sel_t b);
    bank_sel_t r;
    case (b)
      BANK_0:  r = BANK_2;
      BANK_1:  r = BANK_0;
      BANK_2:  r = BANK_1;
      default: r = BANK_0;
    endcase
    return r;
  endfunction

  // Bank that takes the next row
  function automatic bank_sel_t next_bank(input bank_sel_t b);
    bank_sel_t r;
    case (b)
      BANK_0:  r = BANK_1;
      BANK_1:  r = BANK_2;
      BANK_2:  r = BANK_0;
      default: r = BANK_0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/gclm_in_if.sv -----
// Input channel of the grid cavity marker: valid/ready with one cell digit.
// Depends on gclm_pkg for the field width.
interface gclm_in_if;
  logic                       valid;
  logic                       ready;
  logic [gclm_pkg::VAL_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

// ----- design/gclm_out_if.sv -----
// Output channel of the grid cavity marker: valid/ready with one marked cell.
// Depends on gclm_pkg for the field widths.
interface gclm_out_if;
  logic                       valid;
  logic                       ready;
  logic [gclm_pkg::ROW_W-1:0] out_row;
  logic [gclm_pkg::COL_W-1:0] out_col;
  logic [gclm_pkg::VAL_W-1:0] out_value;
  logic                       is_cavity;
  logic                       last_of_grid;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output is_cavity, output last_of_grid, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input is_cavity, input last_of_grid, output ready);
endinterface

// ----- design/gclm_line_bank.sv -----
// One row store: single write port, two registered read ports.
// Depends on gclm_pkg for the cell width.
module gclm_line_bank #(
  parameter int DEPTH = gclm_pkg::MAX_SIZE_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [gclm_pkg::VAL_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr0,
  input  logic [AW-1:0]              raddr1,
  output logic [gclm_pkg::VAL_W-1:0] rdata0,
  output logic [gclm_pkg::VAL_W-1:0] rdata1
);

  logic [gclm_pkg::VAL_W-1:0] mem [DEPTH];

  // Store the arriving cell
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the column and its right neighbour; hold while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ----- design/gclm_out_stage.sv -----
// Result register of the grid cavity marker: sends up to two results per cell.
// Depends on gclm_pkg (result_t, pend_t) and the gclm_out_if interface.
module gclm_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  gclm_pkg::pend_t   take_pend,
  input  gclm_pkg::result_t res_a,
  input  gclm_pkg::result_t res_b,
  output logic              can_take,
  gclm_out_if.source        out_ch
);

  gclm_pkg::pend_t   pend;
  gclm_pkg::pend_t   pend_after;
  gclm_pkg::pend_t   pend_next;
  gclm_pkg::result_t out_data;
  gclm_pkg::result_t pick;
  logic              out_valid;
  logic              out_valid_next;
  logic              load_ok;
  logic              send;

  // Move the oldest owed result into the output register when it is free
  always_comb begin
    load_ok    = !out_valid || out_ch.ready;
    send       = (pend.a || pend.b) && load_ok;
    pick       = pend.a ? res_a : res_b;
    pend_after = pend;
    if (send) begin
      if (pend.a) begin
        pend_after.a = 1'b0;
      end else begin
        pend_after.b = 1'b0;
      end
    end
    can_take       = !pend_after.a && !pend_after.b;
    pend_next      = take ? take_pend : pend_after;
    out_valid_next = send ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (send) begin
      out_data <= pick;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.out_row      = out_data.row;
  assign out_ch.out_col      = out_data.col;
  assign out_ch.out_value    = out_data.value;
  assign out_ch.is_cavity    = out_data.cav;
  assign out_ch.last_of_grid = out_data.last;

endmodule

// ----- design/grid_cross_local_max_marker_top.sv -----
// Grid cavity marker. A square grid of digits arrives in raster order, one cell
// per request. For each arriving cell (row, col) the block sends cell (row-1, col)
// with is_cavity set when that cell is interior and strictly above each cell that
// shares an edge with it; in the last row it also sends the arriving cell itself,
// and flags the final result of the grid. Row 0 cells send nothing (unless the grid
// is one row). Rate: one cell per cycle while out_ch is ready; on the last row each
// cell yields two results and the single output register sends one per cycle, so
// input waits for both to be loaded. Results pass the compare and output
// registers. Three rotating MAX_SIZE-entry row banks supply the neighbours, and no
// clearing pass is needed after reset. Writing grid_size restarts at cell (0, 0).
// Depends on gclm_pkg, gclm_in_if, gclm_out_if, gclm_line_bank, gclm_out_stage.
module grid_cross_local_max_marker_top #(
  parameter int MAX_SIZE = gclm_pkg::MAX_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [gclm_pkg::CFG_W-1:0] cfg_wdata,
  gclm_in_if.sink                    in_ch,
  gclm_out_if.source                 out_ch
);

  localparam int AW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int NCAP = (MAX_SIZE < 255) ? MAX_SIZE : 255;
  localparam int CW   = gclm_pkg::CW;
  localparam int VW   = gclm_pkg::VAL_W;

  logic [CW-1:0]       n_m1;
  logic [CW-1:0]       row_count;
  logic [CW-1:0]       col_count;
  gclm_pkg::bank_sel_t cur_bank;
  logic                accept;
  logic                can_take;
  logic                col_end;
  logic                row_end;
  logic [2:0]          bank_we;
  logic [VW-1:0]       bank_rd0 [3];
  logic [VW-1:0]       bank_rd1 [3];

  // Compare stage
  logic [CW-1:0]       s1_row;
  logic [CW-1:0]       s1_col;
  logic [VW-1:0]       s1_value;
  logic                s1_interior;
  logic                s1_last;
  gclm_pkg::bank_sel_t s1_bank;
  gclm_pkg::bank_sel_t prev_sel;
  gclm_pkg::bank_sel_t older_sel;
  logic [VW-1:0]       left;
  logic [VW-1:0]       mid;
  logic [VW-1:0]       right;
  logic [VW-1:0]       up;
  logic                cav;
  gclm_pkg::pend_t     take_pend;
  gclm_pkg::result_t   res_a;
  gclm_pkg::result_t   res_b;

  assign in_ch.ready = can_take;
  assign accept      = in_ch.valid && can_take;
  assign col_end     = (col_count == n_m1);
  assign row_end     = (row_count == n_m1);

  // Hold the effective size minus one; zero acts as one, large sizes clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      n_m1 <= '0;
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        n_m1 <= '0;
      end else if (int'(cfg_wdata) > NCAP) begin
        n_m1 <= CW'(NCAP - 1);
      end else begin
        n_m1 <= CW'(cfg_wdata - 1'b1);
      end
    end
  end

  // Advance the raster position and rotate bank roles at each row end
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      cur_bank  <= gclm_pkg::BANK_0;
    end else if (cfg_we) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_count <= '0;
        cur_bank  <= gclm_pkg::next_bank(cur_bank);
        row_count <= row_end ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // Write the arriving cell into the bank of the current row
  always_comb begin
    bank_we = '0;
    case (cur_bank)
      gclm_pkg::BANK_0: bank_we[0] = accept;
      gclm_pkg::BANK_1: bank_we[1] = accept;
      gclm_pkg::BANK_2: bank_we[2] = accept;
      default:          bank_we    = '0;
    endcase
  end

  for (genvar b = 0; b < 3; b++) begin : g_bank
    gclm_line_bank #(
      .DEPTH (MAX_SIZE),
      .AW    (AW)
    ) u_bank (
      .clk    (clk),
      .we     (bank_we[b]),
      .waddr  (AW'(col_count)),
      .wdata  (in_ch.cell_value),
      .re     (accept),
      .raddr0 (AW'(col_count)),
      .raddr1 (AW'(col_count + 1'b1)),
      .rdata0 (bank_rd0[b]),
      .rdata1 (bank_rd1[b])
    );
  end

  // Capture the accepted cell and its position flags
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row      <= row_count;
      s1_col      <= col_count;
      s1_value    <= in_ch.cell_value;
      s1_interior <= (row_count > CW'(1)) && (col_count != '0) && (col_count < n_m1);
      s1_last     <= col_end;
      s1_bank     <= cur_bank;
      left        <= mid;
    end
  end

  // Pick the row above and the row two above from the rotating banks
  always_comb begin
    prev_sel  = gclm_pkg::prev_bank(s1_bank);
    older_sel = gclm_pkg::prev_bank(prev_sel);
    case (prev_sel)
      gclm_pkg::BANK_0: begin mid = bank_rd0[0]; right = bank_rd1[0]; end
      gclm_pkg::BANK_1: begin mid = bank_rd0[1]; right = bank_rd1[1]; end
      gclm_pkg::BANK_2: begin mid = bank_rd0[2]; right = bank_rd1[2]; end
      default:          begin mid = bank_rd0[0]; right = bank_rd1[0]; end
    endcase
    case (older_sel)
      gclm_pkg::BANK_0: up = bank_rd0[0];
      gclm_pkg::BANK_1: up = bank_rd0[1];
      gclm_pkg::BANK_2: up = bank_rd0[2];
      default:          up = bank_rd0[0];
    endcase
  end

  // Compare against the edge neighbours above, below, left and right and form both results
  always_comb begin
    cav = s1_interior && (mid > up) && (mid > s1_value) && (mid > left) && (mid > right);
    res_a.row   = gclm_pkg::ROW_W'(s1_row - 1'b1);
    res_a.col   = gclm_pkg::COL_W'(s1_col);
    res_a.value = mid;
    res_a.cav   = cav;
    res_a.last  = 1'b0;
    res_b.row   = gclm_pkg::ROW_W'(s1_row);
    res_b.col   = gclm_pkg::COL_W'(s1_col);
    res_b.value = s1_value;
    res_b.cav   = 1'b0;
    res_b.last  = s1_last;
    take_pend.a = (row_count != '0);
    take_pend.b = row_end;
  end

  gclm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (accept),
    .take_pend (take_pend),
    .res_a     (res_a),
    .res_b     (res_b),
    .can_take  (can_take),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_col_bound : assert property (@(posedge clk) disable iff (rst)
    (col_count <= n_m1) && (row_count <= n_m1))
    else $error("raster position beyond grid size");

  a_cfg_restart : assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (row_count == '0) && (col_count == '0))
    else $error("grid not restarted after size write");

  a_row_hold : assert property (@(posedge clk) disable iff (rst)
    (accept && !col_end && !cfg_we) |=> $stable(row_count))
    else $error("row advanced before end of row");
`endif

endmodule
